[rtl/tpe_pkg.sv]
// ----------------------------------------------------------------------------
// tpe_pkg: shared types and constants of the turning point extractor
// Point kinds, bundle sizes and the side-band struct that rides the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

  // defaults for top level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // one input beat yields at most this many points
  localparam int MAX_POINTS     = 3;
  localparam int POINT_IDX_BITS = 2;

  // point kind codes
  localparam logic KIND_VALLEY = 1'b0;
  localparam logic KIND_PEAK   = 1'b1;

  // per-bundle control: kind and last flag of each slot, number of slots used
  typedef struct packed {
    logic [MAX_POINTS-1:0]     kind;
    logic [MAX_POINTS-1:0]     last;
    logic [POINT_IDX_BITS-1:0] count;
  } tpe_ctrl_t;

endpackage

`default_nettype wire

[rtl/tpe_front.sv]
// ----------------------------------------------------------------------------
// tpe_front: sample classifier
// Tracks the record state, finds reversals and end points, and packs the
// points caused by one sample into a bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_front #(
  parameter int SAMPLE_BITS = tpe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                     sample,
  input  logic                                              end_of_record,
  output logic                                              push_valid,
  input  logic                                              push_ready,
  output logic [tpe_pkg::MAX_POINTS-1:0][SAMPLE_BITS-1:0]  push_values,
  output tpe_pkg::tpe_ctrl_t                                push_ctrl
);

  // record state
  logic signed [SAMPLE_BITS-1:0] prior_distinct;
  logic signed [SAMPLE_BITS-1:0] start_value;
  logic                          seen_any;
  logic                          rising;
  logic                          seen_step;
  logic                          start_pending;
  logic                          kind_emitted;

  logic signed [SAMPLE_BITS-1:0] prior_distinct_next;
  logic signed [SAMPLE_BITS-1:0] start_value_next;
  logic                          rising_next;
  logic                          seen_step_next;
  logic                          start_pending_next;
  logic                          kind_emitted_next;

  logic diff;
  logic up;
  logic step;
  logic rev;
  logic start_high;
  logic in_fire;

  // four candidate points: held start, reversal, and two closing points
  logic [3:0]                        cand_ok;
  logic [3:0][SAMPLE_BITS-1:0]       cand_val;
  logic [3:0]                        cand_kind;
  logic [3:0]                        cand_last;
  logic [tpe_pkg::POINT_IDX_BITS:0]  n;

  assign in_ready = push_ready;
  assign in_fire  = in_valid && in_ready;

  // classify the new sample against the last distinct one
  always_comb begin
    diff = (sample != prior_distinct);
    up   = (sample > prior_distinct);
    step = seen_any && diff;
    rev  = step && seen_step && (up != rising);

    prior_distinct_next = (!seen_any || diff) ? sample : prior_distinct;
    start_value_next    = seen_any ? start_value : sample;
    seen_step_next      = seen_any ? (seen_step || diff) : 1'b0;
    start_pending_next  = seen_any ? (start_pending && !rev) : 1'b1;
    kind_emitted_next   = rev ? rising : kind_emitted;
    rising_next         = step ? up : rising;
    start_high          = (start_value_next > prior_distinct_next);
  end

  // candidate points in emission order
  always_comb begin
    cand_ok[0]   = rev && start_pending;
    cand_val[0]  = start_value;
    cand_kind[0] = !rising;
    cand_last[0] = 1'b0;

    cand_ok[1]   = rev;
    cand_val[1]  = prior_distinct;
    cand_kind[1] = rising;
    cand_last[1] = 1'b0;

    cand_ok[2] = end_of_record;
    if (!seen_step_next) begin
      // single distinct value closes as a valley
      cand_val[2]  = prior_distinct_next;
      cand_kind[2] = tpe_pkg::KIND_VALLEY;
      cand_last[2] = 1'b1;
    end else if (start_pending_next) begin
      // no interior reversal: start first, its kind set by the compare
      cand_val[2]  = start_value_next;
      cand_kind[2] = start_high ? tpe_pkg::KIND_PEAK : tpe_pkg::KIND_VALLEY;
      cand_last[2] = 1'b0;
    end else begin
      cand_val[2]  = prior_distinct_next;
      cand_kind[2] = !kind_emitted_next;
      cand_last[2] = 1'b1;
    end

    cand_ok[3]   = end_of_record && seen_step_next && start_pending_next;
    cand_val[3]  = prior_distinct_next;
    cand_kind[3] = start_high ? tpe_pkg::KIND_VALLEY : tpe_pkg::KIND_PEAK;
    cand_last[3] = 1'b1;
  end

  // compact the candidates into bundle slots
  always_comb begin
    push_values    = '0;
    push_ctrl      = '0;
    n              = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_ok[i] && (n < (tpe_pkg::POINT_IDX_BITS+1)'(tpe_pkg::MAX_POINTS))) begin
        push_values[n[tpe_pkg::POINT_IDX_BITS-1:0]]    = cand_val[i];
        push_ctrl.kind[n[tpe_pkg::POINT_IDX_BITS-1:0]] = cand_kind[i];
        push_ctrl.last[n[tpe_pkg::POINT_IDX_BITS-1:0]] = cand_last[i];
        n = n + 1'b1;
      end
    end
    push_ctrl.count = n[tpe_pkg::POINT_IDX_BITS-1:0];
    push_valid      = in_fire && (n != '0);
  end

  // record state update; end of record returns to the reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_distinct <= '0;
      start_value    <= '0;
      seen_any       <= 1'b0;
      rising         <= 1'b0;
      seen_step      <= 1'b0;
      start_pending  <= 1'b1;
      kind_emitted   <= 1'b0;
    end else if (in_fire) begin
      if (end_of_record) begin
        prior_distinct <= '0;
        start_value    <= '0;
        seen_any       <= 1'b0;
        rising         <= 1'b0;
        seen_step      <= 1'b0;
        start_pending  <= 1'b1;
        kind_emitted   <= 1'b0;
      end else begin
        prior_distinct <= prior_distinct_next;
        start_value    <= start_value_next;
        seen_any       <= 1'b1;
        rising         <= rising_next;
        seen_step      <= seen_step_next;
        start_pending  <= start_pending_next;
        kind_emitted   <= kind_emitted_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tpe_queue.sv]
// ----------------------------------------------------------------------------
// tpe_queue: point bundle queue
// Small register FIFO between classifier and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [LW-1:0]    level;
  logic             push;
  logic             pop;

  assign push_ready = (level != LW'(DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  // pointer distance must agree with the fill level
  a_level_ptrs: assert property (@(posedge clk) disable iff (rst)
    (level != '0 && level != LW'(DEPTH)) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with level");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (level == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue empty with pointers apart");

  a_level_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level == $past(level) + 1'b1))
    else $error("queue level did not advance on push");

endmodule

`default_nettype wire

[rtl/tpe_back.sv]
// ----------------------------------------------------------------------------
// tpe_back: point sequencer
// Holds one bundle and sends its points one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_back #(
  parameter int SAMPLE_BITS = tpe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             q_valid,
  output logic                                             q_ready,
  input  logic [tpe_pkg::MAX_POINTS-1:0][SAMPLE_BITS-1:0] q_values,
  input  tpe_pkg::tpe_ctrl_t                               q_ctrl,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]                    point_value,
  output logic                                             point_kind,
  output logic                                             point_last
);

  logic                                             busy;
  logic [tpe_pkg::POINT_IDX_BITS-1:0]               idx;
  logic [tpe_pkg::MAX_POINTS-1:0][SAMPLE_BITS-1:0]  cur_values;
  tpe_pkg::tpe_ctrl_t                               cur_ctrl;
  logic                                             out_fire;
  logic                                             last_slot;
  logic                                             load;

  assign out_valid   = busy;
  assign point_value = cur_values[idx];
  assign point_kind  = cur_ctrl.kind[idx];
  assign point_last  = cur_ctrl.last[idx];

  // a new bundle loads in the same cycle the old one finishes
  assign out_fire  = busy && out_ready;
  assign last_slot = (idx == cur_ctrl.count - 1'b1);
  assign q_ready   = !busy || (out_fire && last_slot);
  assign load      = q_valid && q_ready;

  // slot sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_fire) begin
      if (last_slot) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // bundle register
  always_ff @(posedge clk) begin
    if (load) begin
      cur_values <= q_values;
      cur_ctrl   <= q_ctrl;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cur_ctrl.count))
    else $error("slot index beyond bundle count");

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (q_ctrl.count != '0))
    else $error("empty bundle taken from queue");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (busy && point_last) |-> last_slot)
    else $error("record end flagged before bundle end");

endmodule

`default_nettype wire

[rtl/turning_point_extractor.sv]
// ----------------------------------------------------------------------------
// turning_point_extractor: peak / valley reversal extraction
// Emits first, last and interior reversal points of a sample record.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, sample, end_of_record | sink
//  out     | out_valid, out_ready, point_value,        | source
//          | point_kind, point_last                    |
//
//  A sample beat is taken each cycle while the bundle queue has room.
//  Each sample yields 0 to 3 points; while out_ready is high the sequencer
//  sends one point per cycle, so sustained output is set by that single beat.
//  A sample beat's first point passes through the queue, then the bundle reg.
//  Synchronous reset clears record state, queue and sequencer.
//  An output stall backs up into the queue; input stalls only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module turning_point_extractor #(
  parameter int SAMPLE_BITS = tpe_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = tpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_record,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] point_value,
  output logic                          point_kind,
  output logic                          point_last
);

  localparam int VALUES_W = tpe_pkg::MAX_POINTS * SAMPLE_BITS;
  localparam int QW       = VALUES_W + $bits(tpe_pkg::tpe_ctrl_t);

  logic                                             push_valid;
  logic                                             push_ready;
  logic [tpe_pkg::MAX_POINTS-1:0][SAMPLE_BITS-1:0]  push_values;
  tpe_pkg::tpe_ctrl_t                               push_ctrl;
  logic                                             q_valid;
  logic                                             q_ready;
  logic [QW-1:0]                                    q_data;
  logic [tpe_pkg::MAX_POINTS-1:0][SAMPLE_BITS-1:0]  q_values;
  tpe_pkg::tpe_ctrl_t                               q_ctrl;

  assign q_values = q_data[QW-1 -: VALUES_W];
  assign q_ctrl   = q_data[$bits(tpe_pkg::tpe_ctrl_t)-1:0];

  // classifier
  tpe_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .end_of_record (end_of_record),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_values   (push_values),
    .push_ctrl     (push_ctrl)
  );

  // bundle queue
  tpe_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_values, push_ctrl}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // point sequencer
  tpe_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_values    (q_values),
    .q_ctrl      (q_ctrl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_value (point_value),
    .point_kind  (point_kind),
    .point_last  (point_last)
  );

endmodule

`default_nettype wire

[bench/point_checker.sv]
// ----------------------------------------------------------------------------
// point_checker: scoreboard for the turning point extractor
// Watches the sample and point channels. It keeps its own copy of the record
// state, works out the points each accepted sample beat must yield, and
// compares every point beat, field by field, with the oldest one expected.
// ----------------------------------------------------------------------------
module point_checker #(
  parameter int SAMPLE_BITS = tpe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_record,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] point_value,
  input  logic                          point_kind,
  input  logic                          point_last,
  output int                            failures,
  output int                            pending_points
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          kind;
    logic                          last;
  } point_t;

  point_t expected_points[$];
  int     fail_tally = 0;

  // record state of the model
  logic signed [SAMPLE_BITS-1:0] last_level;
  logic signed [SAMPLE_BITS-1:0] first_level;
  logic                          have_sample;
  logic                          going_up;
  logic                          have_step;
  logic                          first_held;
  logic                          last_kind;

  task automatic clear_record();
    last_level  = '0;
    first_level = '0;
    have_sample = 1'b0;
    going_up    = 1'b0;
    have_step   = 1'b0;
    first_held  = 1'b1;
    last_kind   = tpe_pkg::KIND_VALLEY;
  endtask

  // work out the points that one sample beat yields
  task automatic extract_points(input logic signed [SAMPLE_BITS-1:0] x, input logic eor);
    logic up;
    logic kind;
    logic first_high;
    if (!have_sample) begin
      have_sample = 1'b1;
      last_level  = x;
      first_level = x;
      first_held  = 1'b1;
      have_step   = 1'b0;
    end else if (x != last_level) begin
      up = x > last_level;
      // direction flips: the previous distinct sample is a turning point
      if (have_step && up != going_up) begin
        kind = going_up ? tpe_pkg::KIND_PEAK : tpe_pkg::KIND_VALLEY;
        if (first_held) begin
          expected_points.push_back('{first_level, ~kind, 1'b0});
          first_held = 1'b0;
        end
        expected_points.push_back('{last_level, kind, 1'b0});
        last_kind = kind;
      end
      going_up  = up;
      have_step = 1'b1;
      last_level = x;
    end

    if (eor) begin
      if (!have_step) begin
        // only one distinct value in the record
        expected_points.push_back('{last_level, tpe_pkg::KIND_VALLEY, 1'b1});
      end else if (first_held) begin
        // monotonic record: lower end is the valley
        first_high = first_level > last_level;
        expected_points.push_back('{first_level, first_high, 1'b0});
        expected_points.push_back('{last_level, ~first_high, 1'b1});
      end else begin
        expected_points.push_back('{last_level, ~last_kind, 1'b1});
      end
      clear_record();
    end
  endtask

  // predict on sample beats, compare on point beats
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      expected_points.delete();
      clear_record();
    end else begin
      if (in_valid && in_ready) begin
        extract_points(sample, end_of_record);
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          if (fail_tally < 10) begin
            $display("unexpected point: value %0d kind %0d last %0d",
                     point_value, point_kind, point_last);
          end
          fail_tally++;
        end else begin
          want = expected_points.pop_front();
          if (want.value !== point_value || want.kind !== point_kind ||
              want.last !== point_last) begin
            if (fail_tally < 10) begin
              $display({"point mismatch: expected value %0d kind %0d last %0d, ",
                        "got value %0d kind %0d last %0d"},
                       want.value, want.kind, want.last,
                       point_value, point_kind, point_last);
            end
            fail_tally++;
          end
        end
      end
    end
    failures       <= fail_tally;
    pending_points <= expected_points.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level bench for the turning point extractor
// Drives sample records through the block with random gaps on both channels
// and gives the verdict from the point checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int W          = tpe_pkg::SAMPLE_BITS_DEF;
  localparam int LIMIT      = 400000;
  localparam int PHASE_BEATS = 95;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] sample = '0;
  logic                end_of_record = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] point_value;
  logic                point_kind;
  logic                point_last;

  int failures;
  int pending_points;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  turning_point_extractor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .end_of_record(end_of_record),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_value(point_value), .point_kind(point_kind), .point_last(point_last)
  );

  point_checker #(.SAMPLE_BITS(W)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .end_of_record(end_of_record),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_value(point_value), .point_kind(point_kind), .point_last(point_last),
    .failures(failures), .pending_points(pending_points)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // one sample beat, with a random gap in front
  task automatic send_sample(input logic signed [W-1:0] v, input logic eor);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    sample        <= v;
    end_of_record <= eor;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every expected point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
  endtask

  // random records: mostly small wiggles around a base so repeats and
  // reversals are frequent, plus full range values and the extremes
  task automatic run_phase(input int s_idle, input int r_idle);
    int sent;
    int len;
    int mode;
    logic signed [W-1:0] base;
    logic signed [W-1:0] v;
    sent = 0;
    send_idle = s_idle;
    recv_idle = r_idle;
    while (sent < PHASE_BEATS) begin
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      base = W'($urandom);
      v    = base;
      for (int i = 0; i < len; i++) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          v = W'(base + $urandom_range(0, 8) - 4);
        end else if (mode < 8) begin
          v = W'($urandom);
        end else if (mode == 8) begin
          if ($urandom_range(0, 1) != 0) begin
            v = {1'b0, {(W-1){1'b1}}};
          end else begin
            v = {1'b1, {(W-1){1'b0}}};
          end
        end
        send_sample(v, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle = 35;
    recv_idle = 84;

    // single sample record at the negative extreme
    send_sample(16'sh8000, 1'b1);
    // one distinct value repeated
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b1);
    // rising record across the full range
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    // falling record
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // peak, valley and end point, with a repeat in the middle
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd50, 1'b0);
    send_sample(16'sd20, 1'b1);
    // reversal on the last beat: held start, peak and end at once
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd5, 1'b1);
    // record closing on a repeated sample after a reversal
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd2, 1'b1);
    // alternating neighbors across zero
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    wait_drained();

    run_phase(35, 84);
    wait_drained();
    run_phase(84, 35);
    wait_drained();
    run_phase(0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending_points == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tpe_pkg.sv
rtl/tpe_front.sv
rtl/tpe_queue.sv
rtl/tpe_back.sv
rtl/turning_point_extractor.sv
bench/point_checker.sv
bench/testbench.sv
